/* sv/pidwr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pidwr_pkg;

  localparam int unsigned ERR_W      = 32;
  localparam int unsigned DIFF_W     = ERR_W + 1;
  localparam int unsigned ACC_W      = 48;
  localparam int unsigned GAIN_W     = 32;
  localparam int unsigned LIM_W      = 31;
  localparam int unsigned DRIVE_W    = 48;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned SUM_W      = 66;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = {1'b0, {(DRIVE_W-1){1'b1}}};
  localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = {1'b1, {(DRIVE_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P,
    REG_GAIN_I,
    REG_GAIN_D,
    REG_WINDUP_LIMIT,
    REG_FLIP_CLEAR,
    REG_TRAPEZOID
  } cfg_reg_e;

  typedef enum logic {
    OP_UPDATE,
    OP_CLEAR
  } op_e;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
    logic [LIM_W-1:0]         windup_limit;
    logic                     flip_clear_enable;
    logic                     trapezoid_enable;
  } cfg_t;

  // Word leaving the integrator stage.
  typedef struct packed {
    logic signed [ERR_W-1:0]  err;
    logic signed [DIFF_W-1:0] diff;
    logic signed [ACC_W-1:0]  integ;
    logic                     clip;
  } integ_word_t;

  // Word leaving the multiplier stage; the integral product is split in two.
  typedef struct packed {
    logic signed [ERR_W+GAIN_W-1:0]      p_err;
    logic signed [DIFF_W+GAIN_W-1:0]     p_diff;
    logic signed [ACC_W-FRAC_W+GAIN_W-1:0] p_ihi;
    logic signed [FRAC_W+1+GAIN_W-1:0]   p_ilo;
    logic                                clip;
  } prod_word_t;

  // Sign comparison with sign(0) taken as zero.
  function automatic logic sign_differs(logic neg_a, logic zero_a, logic neg_b, logic zero_b);
    return (neg_a != neg_b) || (zero_a != zero_b);
  endfunction

endpackage

`default_nettype wire

/* sv/pidwr_regs.sv */
`timescale 1ns / 1ps
`default_nettype none

module pidwr_regs
  import pidwr_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                       cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_GAIN_P:       cfg_d.gain_p = $signed(cfg_data_i[GAIN_W-1:0]);
        REG_GAIN_I:       cfg_d.gain_i = $signed(cfg_data_i[GAIN_W-1:0]);
        REG_GAIN_D:       cfg_d.gain_d = $signed(cfg_data_i[GAIN_W-1:0]);
        REG_WINDUP_LIMIT: cfg_d.windup_limit = cfg_data_i[LIM_W-1:0];
        REG_FLIP_CLEAR:   cfg_d.flip_clear_enable = cfg_data_i[0];
        REG_TRAPEZOID:    cfg_d.trapezoid_enable = cfg_data_i[0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* sv/pidwr_integ.sv */
`timescale 1ns / 1ps
`default_nettype none

module pidwr_integ
  import pidwr_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire cfg_t                    cfg_i,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic                    op_i,
  input  wire logic signed [ERR_W-1:0] error_in_i,
  output logic                         word_valid_o,
  input  wire logic                    word_ready_i,
  output integ_word_t                  word_o
);

  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [ERR_W-1:0] last_q, last_d;
  logic                    valid_q;
  integ_word_t             word_q, word_d;

  logic                    in_fire;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] pair_sum;
  logic signed [ERR_W-1:0] incr;
  logic signed [ACC_W:0]   acc_sum;
  logic signed [ACC_W-1:0] acc_sat;
  logic                    acc_ovf;
  logic [ERR_W-1:0]        abs_err;
  logic                    trap_sel;
  logic                    flip_hit;
  logic                    windup_hit;

  assign in_ready_o = !valid_q || word_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    diff     = {error_in_i[ERR_W-1], error_in_i} - {last_q[ERR_W-1], last_q};
    pair_sum = {error_in_i[ERR_W-1], error_in_i} + {last_q[ERR_W-1], last_q};
    trap_sel = cfg_i.trapezoid_enable &&
               sign_differs(diff[DIFF_W-1], diff == '0,
                            error_in_i[ERR_W-1], error_in_i == '0);
    // Arithmetic halving of the pair sum rounds towards minus infinity.
    incr     = trap_sel ? pair_sum[DIFF_W-1:1] : error_in_i;
    acc_sum  = {acc_q[ACC_W-1], acc_q} + {{(ACC_W-ERR_W+1){incr[ERR_W-1]}}, incr};
    acc_ovf  = acc_sum[ACC_W] != acc_sum[ACC_W-1];
    acc_sat  = acc_ovf ? (acc_sum[ACC_W] ? ACC_MIN : ACC_MAX) : acc_sum[ACC_W-1:0];
    abs_err  = error_in_i[ERR_W-1] ? (~error_in_i + 1'b1) : error_in_i;
    flip_hit = cfg_i.flip_clear_enable &&
               sign_differs(error_in_i[ERR_W-1], error_in_i == '0,
                            last_q[ERR_W-1], last_q == '0);
    windup_hit = (cfg_i.windup_limit != '0) && (abs_err > {1'b0, cfg_i.windup_limit});

    acc_d  = acc_q;
    last_d = last_q;
    word_d = word_q;
    if (in_fire) begin
      if (op_e'(op_i) == OP_CLEAR) begin
        acc_d  = '0;
        last_d = '0;
        word_d = '0;
      end else begin
        acc_d        = (flip_hit || windup_hit) ? '0 : acc_sat;
        last_d       = error_in_i;
        word_d.err   = error_in_i;
        word_d.diff  = diff;
        word_d.integ = acc_d;
        word_d.clip  = acc_ovf;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      last_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      acc_q  <= acc_d;
      last_q <= last_d;
      if (in_ready_o) begin
        valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_valid_o = valid_q;
  assign word_o       = word_q;

  a_clear_zeroes_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && op_i |=> acc_q == '0 && last_q == '0)
    else $error("clear word did not zero the integrator state");

  a_last_follows_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !op_i |=> last_q == $past(error_in_i))
    else $error("previous error not taken from the accepted word");

  a_windup_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !op_i && windup_hit |=> acc_q == '0)
    else $error("integral kept beyond the windup limit");

  a_flip_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !op_i && flip_hit |=> acc_q == '0)
    else $error("integral kept across an error sign change");

  a_word_tracks_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> word_q.integ == acc_q)
    else $error("forwarded integral differs from the stored one");

endmodule

`default_nettype wire

/* sv/pidwr_mult.sv */
`timescale 1ns / 1ps
`default_nettype none

module pidwr_mult
  import pidwr_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cfg_t cfg_i,
  input  wire logic word_valid_i,
  output logic      word_ready_o,
  input  wire integ_word_t word_i,
  output logic      prod_valid_o,
  input  wire logic prod_ready_i,
  output prod_word_t prod_o
);

  logic       valid_q;
  prod_word_t prod_q, prod_d;

  logic signed [ACC_W-FRAC_W-1:0] integ_hi;
  logic signed [FRAC_W:0]         integ_lo;

  assign word_ready_o = !valid_q || prod_ready_i;

  // The 48-bit integral is multiplied as a signed upper part and an
  // unsigned lower part so that no product exceeds 33 by 32 bits.
  always_comb begin
    integ_hi      = word_i.integ[ACC_W-1:FRAC_W];
    integ_lo      = {1'b0, word_i.integ[FRAC_W-1:0]};
    prod_d.p_err  = word_i.err * cfg_i.gain_p;
    prod_d.p_diff = word_i.diff * cfg_i.gain_d;
    prod_d.p_ihi  = integ_hi * cfg_i.gain_i;
    prod_d.p_ilo  = integ_lo * cfg_i.gain_i;
    prod_d.clip   = word_i.clip;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (word_ready_o) begin
      valid_q <= word_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (word_ready_o && word_valid_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_valid_o = valid_q;
  assign prod_o       = prod_q;

endmodule

`default_nettype wire

/* sv/pidwr_sum.sv */
`timescale 1ns / 1ps
`default_nettype none

module pidwr_sum
  import pidwr_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 prod_valid_i,
  output logic                      prod_ready_o,
  input  wire prod_word_t           prod_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic signed [DRIVE_W-1:0] drive_o,
  output logic                      saturated_o
);

  localparam int unsigned T_ERR_W  = ERR_W + GAIN_W - FRAC_W;
  localparam int unsigned T_DIFF_W = DIFF_W + GAIN_W - FRAC_W;
  localparam int unsigned T_IHI_W  = ACC_W - FRAC_W + GAIN_W;
  localparam int unsigned T_ILO_W  = GAIN_W + 1;

  logic                    sum_valid_q;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic                    sum_clip_q;
  logic                    sum_ready;

  logic                      out_valid_q;
  logic signed [DRIVE_W-1:0] drive_q, drive_d;
  logic                      sat_q, sat_d;

  logic [T_ERR_W-1:0]  t_err;
  logic [T_DIFF_W-1:0] t_diff;
  logic [T_IHI_W-1:0]  t_ihi;
  logic [T_ILO_W-1:0]  t_ilo;
  logic                drive_ovf;

  assign sum_ready    = !out_valid_q || out_ready_i;
  assign prod_ready_o = !sum_valid_q || sum_ready;

  // Dropping the low fraction bits of each product floors it; the upper
  // integral product already sits at the output scale.
  always_comb begin
    t_err  = prod_i.p_err[ERR_W+GAIN_W-1:FRAC_W];
    t_diff = prod_i.p_diff[DIFF_W+GAIN_W-1:FRAC_W];
    t_ihi  = prod_i.p_ihi;
    t_ilo  = prod_i.p_ilo[FRAC_W+GAIN_W:FRAC_W];
    sum_d  = $signed({{(SUM_W-T_ERR_W){t_err[T_ERR_W-1]}}, t_err})
           + $signed({{(SUM_W-T_DIFF_W){t_diff[T_DIFF_W-1]}}, t_diff})
           + $signed({{(SUM_W-T_IHI_W){t_ihi[T_IHI_W-1]}}, t_ihi})
           + $signed({{(SUM_W-T_ILO_W){t_ilo[T_ILO_W-1]}}, t_ilo});
  end

  always_comb begin
    drive_ovf = !((&sum_q[SUM_W-1:DRIVE_W-1]) || !(|sum_q[SUM_W-1:DRIVE_W-1]));
    drive_d   = drive_ovf ? (sum_q[SUM_W-1] ? DRIVE_MIN : DRIVE_MAX)
                          : sum_q[DRIVE_W-1:0];
    sat_d     = drive_ovf || sum_clip_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (prod_ready_o) begin
        sum_valid_q <= prod_valid_i;
      end
      if (sum_ready) begin
        out_valid_q <= sum_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_ready_o && prod_valid_i) begin
      sum_q      <= sum_d;
      sum_clip_q <= prod_i.clip;
    end
    if (sum_ready && sum_valid_q) begin
      drive_q <= drive_d;
      sat_q   <= sat_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;
  assign saturated_o = sat_q;

  a_clip_carried: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_ready && sum_valid_q && sum_clip_q |=> saturated_o)
    else $error("integral clipping lost on the way to the output");

  a_overflow_flagged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_ready && sum_valid_q && drive_ovf |=> saturated_o)
    else $error("clipped drive not flagged");

  a_in_range_passes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_ready && sum_valid_q && !drive_ovf |=> drive_o == $past(sum_q[DRIVE_W-1:0]))
    else $error("drive altered although within range");

endmodule

`default_nettype wire

/* sv/pid_controller_windup_reset.sv */
// An accepted word passes the integrator, product, sum and drive registers in
// turn. Throughput: one word per cycle while the output is not stalled; the
// integral and previous error are updated in the accepting cycle, and the
// gain products then flow down a pipeline. The output register lets a new
// word be accepted while a result waits. Reset clears the gains, the limit, both
// mode flags, the integral and the previous error, and empties the pipeline.
`timescale 1ns / 1ps
`default_nettype none

module pid_controller_windup_reset
  import pidwr_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic                    op_i,
  input  wire logic signed [ERR_W-1:0] error_in_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic signed [DRIVE_W-1:0]    drive_o,
  output logic                         saturated_o
);

  cfg_t        cfg;
  integ_word_t integ_word;
  logic        integ_valid;
  logic        integ_ready;
  prod_word_t  prod_word;
  logic        prod_valid;
  logic        prod_ready;

  pidwr_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  pidwr_integ u_integ (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .error_in_i   (error_in_i),
    .word_valid_o (integ_valid),
    .word_ready_i (integ_ready),
    .word_o       (integ_word)
  );

  pidwr_mult u_mult (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .word_valid_i (integ_valid),
    .word_ready_o (integ_ready),
    .word_i       (integ_word),
    .prod_valid_o (prod_valid),
    .prod_ready_i (prod_ready),
    .prod_o       (prod_word)
  );

  pidwr_sum u_sum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .prod_valid_i (prod_valid),
    .prod_ready_o (prod_ready),
    .prod_i       (prod_word),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .drive_o      (drive_o),
    .saturated_o  (saturated_o)
  );

endmodule

`default_nettype wire

/* test/tb_pid_controller_windup_reset.sv */
`timescale 1ns / 1ps

module tb_pid_controller_windup_reset;
  import pidwr_pkg::*;

  // The two spare indexes decode to no register; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned SOAK_WORDS    = 4;
  localparam int unsigned PHASE_WORDS   = 230;
  localparam int unsigned NUM_PHASES    = 8;

  localparam logic signed [ERR_W-1:0] ERR_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [ERR_W-1:0] ERR_MIN = 32'sh8000_0000;

  typedef struct packed {
    op_e                     op;
    logic signed [ERR_W-1:0] err;
  } sample_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      sat;
  } drive_word_t;

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0]       cfg_data_i  = '0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_ready_o;
  logic                        op_i        = 1'b0;
  logic signed [ERR_W-1:0]     error_in_i  = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic signed [DRIVE_W-1:0]   drive_o;
  logic                        saturated_o;

  pid_controller_windup_reset DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .error_in_i (error_in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .drive_o    (drive_o),
    .saturated_o(saturated_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Controller copy: configuration and state as the block should hold them.
  logic signed [GAIN_W-1:0] kp        = '0;
  logic signed [GAIN_W-1:0] ki        = '0;
  logic signed [GAIN_W-1:0] kd        = '0;
  logic [LIM_W-1:0]         wlim      = '0;
  logic                     flip_en   = 1'b0;
  logic                     trap_en   = 1'b0;
  logic signed [ACC_W-1:0]  integ_acc = '0;
  logic signed [ERR_W-1:0]  prev_err  = '0;

  sample_t     pending_q[$];
  drive_word_t expected_drive_q[$];

  int unsigned queued_count   = 0;
  int unsigned accepted_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned idle_in_pct    = 0;
  int unsigned stall_out_pct  = 0;
  logic        in_fire_q      = 1'b0;
  longint      walk_err       = 0;

  function automatic int sign_of(longint x);
    return (x > 0) ? 1 : ((x < 0) ? -1 : 0);
  endfunction

  function automatic drive_word_t predict_drive(sample_t s);
    longint             e;
    longint             prev;
    longint             d;
    longint             inc;
    longint             sum_i;
    logic signed [79:0] e_w, d_w, i_w, gp_w, gi_w, gd_w, total, hi_lim, lo_lim;
    logic               clip;
    drive_word_t        r;
    clip = 1'b0;
    if (s.op == OP_CLEAR) begin
      integ_acc = '0;
      prev_err  = '0;
      r.drive   = '0;
      r.sat     = 1'b0;
      return r;
    end
    e    = $signed(s.err);
    prev = prev_err;
    d    = e - prev;
    // The trapezoid step only applies when the slope points against the error.
    if (trap_en && sign_of(d) != sign_of(e)) begin
      inc = (e + prev) >>> 1;
    end else begin
      inc = e;
    end
    sum_i = longint'(integ_acc) + inc;
    if (sum_i > longint'(ACC_MAX)) begin
      sum_i = ACC_MAX;
      clip  = 1'b1;
    end else if (sum_i < longint'(ACC_MIN)) begin
      sum_i = ACC_MIN;
      clip  = 1'b1;
    end
    if (flip_en && sign_of(e) != sign_of(prev)) sum_i = 0;
    if (wlim != '0 && ((e < 0) ? -e : e) > longint'(wlim)) sum_i = 0;
    integ_acc = sum_i[ACC_W-1:0];
    prev_err  = s.err;

    e_w    = e;
    d_w    = d;
    i_w    = sum_i;
    gp_w   = kp;
    gi_w   = ki;
    gd_w   = kd;
    total  = ((e_w * gp_w) >>> FRAC_W) + ((i_w * gi_w) >>> FRAC_W) + ((d_w * gd_w) >>> FRAC_W);
    hi_lim = DRIVE_MAX;
    lo_lim = DRIVE_MIN;
    if (total > hi_lim) begin
      total = hi_lim;
      clip  = 1'b1;
    end else if (total < lo_lim) begin
      total = lo_lim;
      clip  = 1'b1;
    end
    r.drive = total[DRIVE_W-1:0];
    r.sat   = clip;
    return r;
  endfunction

  // Driver: a new word goes out only once the previous one has been taken.
  always @(negedge clk_i) begin
    sample_t s;
    if (rst_ni && (!in_valid_i || in_fire_q)) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= idle_in_pct) begin
        s = pending_q.pop_front();
        in_valid_i <= 1'b1;
        op_i       <= s.op;
        error_in_i <= s.err;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_ready_i <= ($urandom_range(99) >= stall_out_pct);
  end

  // Monitor: predicts on every accepted sample and checks every accepted result.
  always @(posedge clk_i) begin
    sample_t     s;
    drive_word_t exp_w;
    in_fire_q <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        s.op  = op_e'(op_i);
        s.err = error_in_i;
        expected_drive_q.push_back(predict_drive(s));
        accepted_count++;
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_drive_q.size() == 0) begin
          $error("unexpected result word: drive %0d, saturated %0b", drive_o, saturated_o);
          mismatch_count++;
        end else begin
          exp_w = expected_drive_q.pop_front();
          if (drive_o !== exp_w.drive) begin
            $error("drive: expected %0d, got %0d", exp_w.drive, drive_o);
            mismatch_count++;
          end
          if (saturated_o !== exp_w.sat) begin
            $error("saturated: expected %0b, got %0b", exp_w.sat, saturated_o);
            mismatch_count++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (queued_count == accepted_count && expected_drive_q.size() == 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(posedge clk_i);
    case (idx)
      REG_GAIN_P:       kp      = data;
      REG_GAIN_I:       ki      = data;
      REG_GAIN_D:       kd      = data;
      REG_WINDUP_LIMIT: wlim    = data[LIM_W-1:0];
      REG_FLIP_CLEAR:   flip_en = data[0];
      REG_TRAPEZOID:    trap_en = data[0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic apply_config(logic [31:0] gp, logic [31:0] gi, logic [31:0] gd,
                              logic [31:0] lim, logic [31:0] flip, logic [31:0] trap);
    write_reg(REG_GAIN_P, gp);
    write_reg(REG_GAIN_I, gi);
    write_reg(REG_GAIN_D, gd);
    write_reg(REG_WINDUP_LIMIT, lim);
    write_reg(REG_FLIP_CLEAR, flip);
    write_reg(REG_TRAPEZOID, trap);
    cfg_we_i = 1'b0;
  endtask

  task automatic queue_word(op_e op, logic signed [ERR_W-1:0] err);
    sample_t s;
    s.op  = op;
    s.err = err;
    pending_q.push_back(s);
    queued_count++;
  endtask

  // Waits until every queued word has been taken and answered, then lets the
  // pipeline settle so that configuration can be changed safely.
  task automatic drain();
    while (accepted_count != queued_count || expected_drive_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_idling(int unsigned mode);
    case (mode)
      0: begin idle_in_pct = 0;  stall_out_pct = 0;  end
      1: begin idle_in_pct = 45; stall_out_pct = 0;  end
      2: begin idle_in_pct = 0;  stall_out_pct = 45; end
      default: begin idle_in_pct = 9; stall_out_pct = 9; end
    endcase
  endtask

  // Mostly a slow random walk, so the integral builds up and crosses zero,
  // mixed with values near zero, extremes and full-range noise.
  function automatic logic signed [ERR_W-1:0] next_error();
    int unsigned             pick;
    logic signed [ERR_W-1:0] r;
    pick = $urandom_range(99);
    if (pick < 55) begin
      walk_err += longint'($urandom_range(131072)) - 65536;
      if (walk_err > longint'(ERR_MAX)) walk_err = ERR_MAX;
      if (walk_err < longint'(ERR_MIN)) walk_err = ERR_MIN;
      r = walk_err[ERR_W-1:0];
    end else if (pick < 70) begin
      r = $urandom_range(6) - 3;
    end else if (pick < 82) begin
      r = $urandom;
    end else if (pick < 92) begin
      case ($urandom_range(4))
        0: r = ERR_MAX;
        1: r = ERR_MIN;
        2: r = '0;
        3: r = -1;
        default: r = 1;
      endcase
    end else begin
      walk_err = longint'($urandom_range(33554432)) - 16777216;
      r = walk_err[ERR_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] pick_gain();
    logic [31:0] g;
    case ($urandom_range(9))
      0: g = 32'h8000_0000;
      1: g = 32'h7FFF_FFFF;
      2: g = '0;
      3, 4: g = $urandom;
      default: g = $urandom_range(32'h0008_0000) - 32'h0004_0000;
    endcase
    return g;
  endfunction

  function automatic logic [31:0] pick_limit();
    logic [31:0] l;
    case ($urandom_range(3))
      0: l = '0;
      1: l = 32'h7FFF_FFFF;
      2: l = $urandom_range(32'h0010_0000, 1);
      default: l = $urandom;
    endcase
    return l;
  endfunction

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Plain PID with all integration modes off.
    set_idling(0);
    apply_config(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, '0, '0, '0);
    queue_word(OP_UPDATE, '0);
    queue_word(OP_UPDATE, ERR_MAX);
    queue_word(OP_UPDATE, ERR_MIN);
    queue_word(OP_UPDATE, ERR_MAX);
    queue_word(OP_UPDATE, -1);
    queue_word(OP_UPDATE, 1);
    queue_word(OP_CLEAR, ERR_MAX);
    queue_word(OP_UPDATE, 5);
    queue_word(OP_UPDATE, -5);
    queue_word(OP_UPDATE, '0);
    drain();

    // Spare indexes are ignored, and upper data bits beyond a register are dropped.
    write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_HI, 32'h1234_5678);
    write_reg(REG_WINDUP_LIMIT, 32'h8000_0010);
    write_reg(REG_FLIP_CLEAR, 32'h0000_0002);
    write_reg(REG_FLIP_CLEAR, 32'hFFFF_FFFF);
    write_reg(REG_TRAPEZOID, 32'h0000_0003);
    cfg_we_i = 1'b0;
    queue_word(OP_UPDATE, 32'sh20);
    queue_word(OP_UPDATE, -32'sh20);
    queue_word(OP_UPDATE, 32'sh10);
    queue_word(OP_UPDATE, 32'sh8);
    queue_word(OP_UPDATE, -32'sh8);
    queue_word(OP_UPDATE, '0);
    queue_word(OP_UPDATE, 3);
    queue_word(OP_UPDATE, 2);
    queue_word(OP_UPDATE, -3);
    queue_word(OP_UPDATE, -1);
    queue_word(OP_CLEAR, '0);
    drain();

    // Extreme gains push the output into saturation.
    apply_config(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, '0, '0, '0);
    queue_word(OP_UPDATE, ERR_MAX);
    queue_word(OP_UPDATE, ERR_MIN);
    queue_word(OP_UPDATE, ERR_MIN);
    drain();

    // Build the integral up in each direction, then clear it beyond the windup limit.
    apply_config('0, 32'h0000_0001, '0, '0, '0, '0);
    queue_word(OP_CLEAR, '0);
    repeat (SOAK_WORDS) queue_word(OP_UPDATE, ERR_MAX);
    drain();
    write_reg(REG_WINDUP_LIMIT, 32'h7FFF_FFFE);
    cfg_we_i = 1'b0;
    queue_word(OP_UPDATE, ERR_MAX);
    drain();
    write_reg(REG_WINDUP_LIMIT, '0);
    cfg_we_i = 1'b0;
    queue_word(OP_CLEAR, '0);
    repeat (SOAK_WORDS) queue_word(OP_UPDATE, ERR_MIN);
    drain();
    write_reg(REG_WINDUP_LIMIT, 32'h7FFF_FFFE);
    cfg_we_i = 1'b0;
    queue_word(OP_UPDATE, ERR_MIN);
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 0) begin
        apply_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 1);
      end else if (ph == 1) begin
        apply_config(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0000_0001, 0, 1);
      end else begin
        apply_config(pick_gain(), pick_gain(), pick_gain(), pick_limit(), $urandom, $urandom);
      end
      set_idling(ph % 4);
      walk_err = 0;
      repeat (PHASE_WORDS) begin
        if ($urandom_range(99) < 4) begin
          queue_word(OP_CLEAR, $urandom);
        end else begin
          queue_word(OP_UPDATE, next_error());
        end
      end
      drain();
    end

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* pid_controller_windup_reset.f */
sv/pidwr_pkg.sv
sv/pidwr_regs.sv
sv/pidwr_integ.sv
sv/pidwr_mult.sv
sv/pidwr_sum.sv
sv/pid_controller_windup_reset.sv
test/tb_pid_controller_windup_reset.sv
